>>> src/assert_macros.svh
// ============================================================================
// Assertion macros
// Clocked assertion shorthands shared by the console writer modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies expectation in the next.
`define TCW_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (nxt)) else $error(msg);

`endif

>>> src/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Shared types and constants of the text console writer.
// ============================================================================
package tcw_pkg;

    // Default geometry and blank cell (space, light gray on black)
    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int BLANK_CELL_DEF = 1824;

    // Full store address wide enough for up to 32768 cells
    localparam int ADDR_MAX_W = 15;

    // Result field widths
    localparam int CHAR_W       = 8;
    localparam int COLOR_W      = 4;
    localparam int CELL_W       = 16;
    localparam int CELL_INDEX_W = 11;
    localparam int ROW_OUT_W    = 5;
    localparam int COL_OUT_W    = 7;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;
    localparam logic [COLOR_W-1:0]   FG_RESET     = 4'd7;
    localparam logic [COLOR_W-1:0]   BG_RESET     = 4'd0;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                    cell_written;
        logic [CELL_INDEX_W-1:0] cell_index;
        logic [CELL_W-1:0]       cell_value;
        logic [ROW_OUT_W-1:0]    cursor_row_out;
        logic [COL_OUT_W-1:0]    cursor_col_out;
        logic                    scrolled;
    } t_result;

    // One queued command: finished result plus full store address
    typedef struct packed {
        t_result               res;
        logic [ADDR_MAX_W-1:0] addr;
    } t_op;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCROLL_WAIT,
        ST_COPY,
        ST_BLANK
    } t_back_state;

endpackage

>>> src/tcw_ifs.sv
// ============================================================================
// tcw interfaces
// Valid/ready channels for characters, results and configuration writes.
// ============================================================================
interface tcw_char_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tcw_result_if import tcw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    cell_written;
    logic [CELL_INDEX_W-1:0] cell_index;
    logic [CELL_W-1:0]       cell_value;
    logic [ROW_OUT_W-1:0]    cursor_row_out;
    logic [COL_OUT_W-1:0]    cursor_col_out;
    logic                    scrolled;

    modport source (output valid, output cell_written, output cell_index,
                    output cell_value, output cursor_row_out,
                    output cursor_col_out, output scrolled, input ready);
    modport sink   (input valid, input cell_written, input cell_index,
                    input cell_value, input cursor_row_out,
                    input cursor_col_out, input scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [COLOR_W-1:0]   wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> src/tcw_front.sv
// ============================================================================
// tcw_front
// Accepts characters, tracks the cursor and colors, builds each result.
// ============================================================================
`include "assert_macros.svh"

module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcw_char_if.sink     i_char,
    tcw_cfg_if.sink      i_cfg,
    input  logic         i_q_full,
    input  t_back_status i_stat,
    output logic         o_push,
    output t_op          o_push_op
);

    localparam int ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RowW = $clog2(ROWS);

    logic [RowW-1:0]    r_row, n_row;
    logic [ColW-1:0]    r_col, n_col;
    logic [COLOR_W-1:0] r_fg, r_bg;

    logic                  accept, is_nl, last_col, at_bottom, wrap;
    logic [ADDR_MAX_W-1:0] lin;

    assign i_char.ready = !i_q_full && !i_stat.clearing;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_char.valid && i_char.ready;

    always_comb begin
        is_nl     = (i_char.char_code == NEWLINE_CODE);
        last_col  = (r_col == ColW'(COLUMNS - 1));
        at_bottom = (r_row == RowW'(ROWS - 1));
        lin       = ADDR_MAX_W'(r_row) * ADDR_MAX_W'(COLUMNS) + ADDR_MAX_W'(r_col);
        wrap      = is_nl || last_col;
        n_col     = wrap ? '0 : r_col + 1'b1;
        n_row     = r_row;
        if (wrap && !at_bottom) begin
            n_row = r_row + 1'b1;
        end

        o_push_op.addr               = lin;
        o_push_op.res.cell_written   = !is_nl;
        o_push_op.res.cell_index     = is_nl ? '0 : CELL_INDEX_W'(lin);
        o_push_op.res.cell_value     = is_nl ? '0 : {r_bg, r_fg, i_char.char_code};
        o_push_op.res.cursor_row_out = ROW_OUT_W'(n_row);
        o_push_op.res.cursor_col_out = COL_OUT_W'(n_col);
        o_push_op.res.scrolled       = wrap && at_bottom;
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                CFG_FG_COLOR: r_fg <= i_cfg.wdata;
                CFG_BG_COLOR: r_bg <= i_cfg.wdata;
                default: ;  // unknown register, dropped
            endcase
        end
    end

    `TCW_ASSERT(a_cursor_in_range, (r_row <= RowW'(ROWS - 1)) && (r_col <= ColW'(COLUMNS - 1)), "cursor left the screen")

endmodule

>>> src/tcw_queue.sv
// ============================================================================
// tcw_queue
// Short command FIFO decoupling the front from the back.
// ============================================================================
`include "assert_macros.svh"

module tcw_queue import tcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    `TCW_ASSERT(a_no_overflow, !(i_push && o_full) && !(i_pop && !o_valid), "queue over/underflow")

endmodule

>>> src/tcw_back.sv
// ============================================================================
// tcw_back
// Owns the screen store: clears it, writes cells, scrolls, issues results.
// ============================================================================
`include "assert_macros.svh"

module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int BLANK_CELL = BLANK_CELL_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_op          i_q_op,
    output logic         o_pop,
    output t_back_status o_stat,
    tcw_result_if.source o_res
);

    localparam int Cells = ROWS * COLUMNS;
    localparam int AW    = $clog2(Cells);
    localparam int PW    = $clog2(Cells + 1);
    localparam logic [CELL_W-1:0] Blank = CELL_W'(BLANK_CELL);

    logic [CELL_W-1:0] r_mem [Cells];
    logic [CELL_W-1:0] r_rd_data;

    t_back_state       r_state, n_state;
    logic [PW-1:0]     r_ptr, n_ptr;
    logic              r_wr_en, n_wr_en;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic [CELL_W-1:0] r_wr_data, n_wr_data;
    logic              r_wr_from_rd, n_wr_from_rd;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic              rd_en;
    logic [CELL_W-1:0] wr_data;

    assign wr_data = r_wr_from_rd ? r_rd_data : r_wr_data;

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_mem[r_wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[AW-1:0]];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_wr_en      = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_wr_data    = r_wr_data;
        n_wr_from_rd = 1'b0;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out        = r_out;
        rd_en        = 1'b0;
        o_pop        = 1'b0;

        unique case (r_state)
            ST_CLEAR, ST_BLANK: begin
                n_wr_en   = 1'b1;
                n_wr_addr = r_ptr[AW-1:0];
                n_wr_data = Blank;
                if (r_ptr == PW'(Cells - 1)) begin
                    n_state = ST_RUN;
                    n_ptr   = '0;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_RUN: begin
                if (i_q_valid && (!r_out_valid || o_res.ready)) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = i_q_op.res;
                    if (i_q_op.res.cell_written) begin
                        n_wr_en   = 1'b1;
                        n_wr_addr = i_q_op.addr[AW-1:0];
                        n_wr_data = i_q_op.res.cell_value;
                    end
                    if (i_q_op.res.scrolled) begin
                        n_state = ST_SCROLL_WAIT;
                    end
                end
            end
            ST_SCROLL_WAIT: begin
                // lets a pending cell write land before the copy reads
                n_ptr   = PW'(COLUMNS);
                n_state = ST_COPY;
            end
            ST_COPY: begin
                rd_en        = 1'b1;
                n_wr_en      = 1'b1;
                n_wr_from_rd = 1'b1;
                n_wr_addr    = AW'(r_ptr - PW'(COLUMNS));
                if (r_ptr == PW'(Cells - 1)) begin
                    n_state = ST_BLANK;
                    n_ptr   = PW'(Cells - COLUMNS);
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_wr_en     <= n_wr_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr    <= n_wr_addr;
        r_wr_data    <= n_wr_data;
        r_wr_from_rd <= n_wr_from_rd;
        r_out        <= n_out;
    end

    assign o_stat.clearing = (r_state == ST_CLEAR);

    assign o_res.valid          = r_out_valid;
    assign o_res.cell_written   = r_out.cell_written;
    assign o_res.cell_index     = r_out.cell_index;
    assign o_res.cell_value     = r_out.cell_value;
    assign o_res.cursor_row_out = r_out.cursor_row_out;
    assign o_res.cursor_col_out = r_out.cursor_col_out;
    assign o_res.scrolled       = r_out.scrolled;

    `TCW_ASSERT_NEXT(a_scroll_starts, o_pop && i_q_op.res.scrolled, r_state == ST_SCROLL_WAIT, "scroll not started")
    `TCW_ASSERT_NEXT(a_result_held, r_out_valid && !o_res.ready, r_out_valid && $stable(r_out), "stalled result lost")
    `TCW_ASSERT(a_no_pop_busy, o_pop |-> (r_state == ST_RUN) && (!r_out_valid || o_res.ready), "pop while busy")

endmodule

>>> src/text_console_writer_top.sv
// ============================================================================
// text_console_writer_top
// Character terminal: prints bytes into a ROWS x COLUMNS cell screen.
// ============================================================================
//
//  Channel   Dir  Payload                                         Handshake
//  --------  ---  ----------------------------------------------  -----------
//  i_char    in   char_code[7:0] (10 = newline)                   valid/ready
//  i_cfg     in   reg_index (0 fg, 1 bg), wdata[3:0]              valid/ready
//  o_result  out  cell_written, cell_index, cell_value,           valid/ready
//                 cursor_row_out, cursor_col_out, scrolled
//
//  Ordinary characters and newlines: one transfer per cycle on each side
//  while o_result is ready and no scroll is running. After reset the screen
//  store is swept to the blank cell, one cell a cycle, with i_char not ready.
//  A scroll keeps the back busy through a wait state, the row copy and the
//  blank row on the single store port; input is taken until the queue fills.
//  o_result stalls hold the result register; the front keeps accepting
//  into the queue, so a waiting result blocks input only once the
//  two-entry queue is full.
//  i_cfg is always ready; writes to other indexes are dropped.
//
module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int BLANK_CELL = BLANK_CELL_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcw_char_if.sink     i_char,
    tcw_cfg_if.sink      i_cfg,
    tcw_result_if.source o_result
);

    // front -> queue
    logic         push;
    t_op          push_op;
    logic         q_full;
    // queue -> back
    logic         q_valid;
    t_op          q_op;
    logic         pop;
    // back -> front: hold input during the clearing sweep
    t_back_status back_stat;

    // Cursor tracking and result build; everything the result needs is
    // known at acceptance, so the front never waits on the store.
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_cfg     (i_cfg),
        .i_q_full  (q_full),
        .i_stat    (back_stat),
        .o_push    (push),
        .o_push_op (push_op)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // Store owner: cell writes, scroll copy, blank fill, result register.
    tcw_back #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .BLANK_CELL (BLANK_CELL)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_pop     (pop),
        .o_stat    (back_stat),
        .o_res     (o_result)
    );

endmodule

>>> tb/tb_text_console_writer_top.sv
// ============================================================================
// tb_text_console_writer_top
// Self-checking bench for the text console writer. A scoreboard class tracks
// the cursor and the color registers, predicts every result, and checks each
// result transfer field by field. Text is sent in bursts with gaps, and the
// result side stalls on its own pattern.
// ============================================================================
module tb_text_console_writer_top import tcw_pkg::*; ();

    // Geometry of the instance under test (package defaults)
    localparam int COLUMNS    = COLUMNS_DEF;
    localparam int ROWS       = ROWS_DEF;
    localparam int BLANK_CELL = BLANK_CELL_DEF;

    // Register indexes the block has no register behind; writes are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Cycles a scroll may keep the back busy after its result has left,
    // plus margin; used before color writes and at the end of the run
    localparam int SETTLE_CYCLES = ROWS * COLUMNS + 16;

    localparam int RANDOM_CHARS = 1950;
    localparam int COLOR_PHASES = 6;

    // ------------------------------------------------------------------------
    // Scoreboard: cursor tracking, expected results, result checks
    // ------------------------------------------------------------------------
    class screen_scoreboard;
        t_result            expected_q[$];
        int                 row;
        int                 col;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        int                 mismatches;
        int                 n_chars;
        int                 n_newlines;
        int                 n_wraps;
        int                 n_scrolls;
        int                 n_results;
        int                 n_cfg;

        function new();
            row        = 0;
            col        = 0;
            fg         = FG_RESET;
            bg         = BG_RESET;
            mismatches = 0;
            n_chars    = 0;
            n_newlines = 0;
            n_wraps    = 0;
            n_scrolls  = 0;
            n_results  = 0;
            n_cfg      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
            n_cfg++;
            case (idx)
                CFG_FG_COLOR: fg = val;
                CFG_BG_COLOR: bg = val;
                default: ;
            endcase
        endfunction

        // Step to the next row; past the bottom the screen scrolls and the
        // cursor parks at the start of the last row.
        function bit advance_row();
            row++;
            if (row >= ROWS) begin
                row = ROWS - 1;
                col = 0;
                n_scrolls++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Accepted character: work out the result it must produce
        function void note_char(logic [CHAR_W-1:0] code);
            t_result r;
            r = '0;
            n_chars++;
            if (code == NEWLINE_CODE) begin
                n_newlines++;
                r.scrolled = advance_row();
                col = 0;
            end else begin
                r.cell_written = 1'b1;
                r.cell_index   = CELL_INDEX_W'(row * COLUMNS + col);
                r.cell_value   = {bg, fg, code};
                col++;
                if (col >= COLUMNS) begin
                    col = 0;
                    n_wraps++;
                    r.scrolled = advance_row();
                end
            end
            r.cursor_row_out = ROW_OUT_W'(row);
            r.cursor_col_out = COL_OUT_W'(col);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                mismatches++;
                $error("result %0d, %s: expected %0d, got %0d",
                       n_results, name, exp_v, got_v);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                $error("result transfer with no pending expectation");
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("cell_written",   exp_r.cell_written,   got.cell_written);
            compare_field("cell_index",     exp_r.cell_index,     got.cell_index);
            compare_field("cell_value",     exp_r.cell_value,     got.cell_value);
            compare_field("cursor_row_out", exp_r.cursor_row_out, got.cursor_row_out);
            compare_field("cursor_col_out", exp_r.cursor_col_out, got.cursor_col_out);
            compare_field("scrolled",       exp_r.scrolled,       got.scrolled);
            n_results++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, instance
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    tcw_char_if   char_ch ();
    tcw_cfg_if    cfg_ch ();
    tcw_result_if res_ch ();

    text_console_writer_top #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .BLANK_CELL (BLANK_CELL)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (res_ch.source)
    );

    screen_scoreboard sb = new();

    // ------------------------------------------------------------------------
    // Monitor. One process observes all three channels at each rising edge,
    // so a color write, a character and a result landing in the
    // same cycle are always handled in that order, independent of how the
    // simulator schedules the driver processes.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.reg_index, cfg_ch.wdata);
            if (char_ch.valid && char_ch.ready)
                sb.note_char(char_ch.char_code);
            if (res_ch.valid && res_ch.ready) begin
                got.cell_written   = res_ch.cell_written;
                got.cell_index     = res_ch.cell_index;
                got.cell_value     = res_ch.cell_value;
                got.cursor_row_out = res_ch.cursor_row_out;
                got.cursor_col_out = res_ch.cursor_col_out;
                got.scrolled       = res_ch.scrolled;
                sb.check_result(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure. After each stretch of random length the mode
    // is drawn anew: free running, coin flip, mostly stalled, or a fixed beat.
    // ------------------------------------------------------------------------
    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_mode;

    t_rx_mode    rx_mode   = RX_FREE;
    int unsigned rx_left   = 0;
    int unsigned rx_beat   = 0;
    logic        rx_ready  = 1'b0;

    assign res_ch.ready = rx_ready;

    always @(posedge i_clk) begin
        rx_beat <= rx_beat + 1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(RX_FREE, RX_BEAT));
            rx_left <= $urandom_range(40, 600);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:   rx_ready <= 1'b1;
            RX_COIN:   rx_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rx_ready <= ($urandom_range(0, 7) == 0);
            default:   rx_ready <= (rx_beat % 5 != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Valid stays high across back-to-back transfers; only a
    // real gap lowers it, so valid never gets two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_char(logic [CHAR_W-1:0] code);
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= code;
        do @(posedge i_clk); while (!char_ch.ready);
    endtask

    task automatic idle_sender(int unsigned cycles);
        if (cycles > 0) begin
            char_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain_results();
        idle_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Both colors plus one write to an index with no register behind it
    task automatic write_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
        logic [CFG_IDX_W-1:0] spare;
        spare = $urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3;
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= CFG_FG_COLOR;
        cfg_ch.wdata     <= fg;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.reg_index <= spare;
        cfg_ch.wdata     <= COLOR_W'($urandom_range(0, 15));
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.reg_index <= CFG_BG_COLOR;
        cfg_ch.wdata     <= bg;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random text: lines of random length, most short, some just around one
    // row (exact wrap, wrap then newline) and some spanning several rows.
    // A line ends with a newline.
    int unsigned line_left = 0;

    function automatic logic [CHAR_W-1:0] next_text_byte();
        if (line_left == 0) begin
            case ($urandom_range(0, 9))
                0:       line_left = COLUMNS;
                1:       line_left = $urandom_range(COLUMNS - 2, COLUMNS + 2);
                2:       line_left = $urandom_range(COLUMNS + 1, 3 * COLUMNS);
                default: line_left = $urandom_range(0, 24);
            endcase
            return NEWLINE_CODE;
        end
        line_left--;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // One stretch of random text in bursts; now and then the sender holds
    // off until everything is back, and some bursts run with no gap at all.
    task automatic send_random_text(int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (sent < count) begin
                    send_char(next_text_byte());
                    sent++;
                end
            end
            case ($urandom_range(0, 19))
                0:       drain_results();
                1, 2, 3,
                4, 5:    ;
                default: idle_sender($urandom_range(1, 12));
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [CHAR_W-1:0] directed_text [$] = '{
        8'h00, 8'hFF, 8'h20, 8'h41, NEWLINE_CODE, NEWLINE_CODE, 8'h7F, 8'h80,
        8'h55, 8'hAA, 8'h09, 8'h0B, 8'h0D, NEWLINE_CODE, 8'h01, 8'hFE
    };

    logic [COLOR_W-1:0] phase_fg [COLOR_PHASES] = '{4'hF, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0};
    logic [COLOR_W-1:0] phase_bg [COLOR_PHASES] = '{4'hF, 4'h0, 4'h0, 4'hF, 4'h0, 4'h0};

    initial begin
        // Sender side inputs known from time zero
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = CFG_FG_COLOR;
        cfg_ch.wdata      = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text under the reset colors. The block sweeps its store
        // after reset; the first transfer simply waits for ready.
        foreach (directed_text[i]) begin
            send_char(directed_text[i]);
            if (i % 5 == 4)
                idle_sender($urandom_range(1, 3));
        end

        // Random phases, each under its own colors: both extremes first,
        // then mixed and random settings
        for (int p = 0; p < COLOR_PHASES; p++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            if (p >= 4)
                write_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
            else
                write_colors(phase_fg[p], phase_bg[p]);
            send_random_text(RANDOM_CHARS / COLOR_PHASES + 1);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            sb.mismatches++;
            $error("%0d expected results never arrived", sb.pending());
        end

        $display("Run covered %0d characters with %0d newlines, %0d row wraps, %0d scrolls",
                 sb.n_chars, sb.n_newlines, sb.n_wraps, sb.n_scrolls);
        $display("and %0d register writes; %0d results checked",
                 sb.n_cfg, sb.n_results);

        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog. Slowest correct run: store sweep plus every character
    // scrolling with heavy result stalls; the limit below is several
    // times that.
    initial begin
        #300_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
